@@ rtl/core/q13_pkg.sv @@
// q13_pkg: constants, types and opcodes shared by the fixed-point alu
// no dependencies
package q13_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned FracBitsDef = 13;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  // one stage of the divider row: item state handed cell to cell
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [WordW-1:0]  a;
    logic [WordW-1:0]  b;
    logic              neg;
    logic [WordW:0]    rem;
    logic [WordW-1:0]  quo;
  } cell_t;

endpackage

@@ rtl/core/q13_cell.sv @@
// q13_cell: one restoring-division step for the reciprocal row
// depends on q13_pkg
module q13_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned NumSteps = 27
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  q13_pkg::cell_t cell_i,
  output q13_pkg::cell_t cell_o
);

  localparam int unsigned W = q13_pkg::WordW;
  localparam int unsigned BitPos = NumSteps - 1 - Step;

  q13_pkg::cell_t cell_d, cell_q;
  logic        valid_q;
  logic [W:0]  trial;
  logic [W:0]  mag;
  logic        num_bit;

  always_comb begin
    mag = {1'b0, (cell_i.neg ? (~cell_i.b + 1'b1) : cell_i.b)};
    // dividend is 2^(NumSteps-1): only its top bit is set
    num_bit = (BitPos == NumSteps - 1);
    trial = {cell_i.rem[W-1:0], num_bit};
    cell_d = cell_i;
    if (cell_i.op == q13_pkg::OpDiv && trial >= mag && mag != '0) begin
      cell_d.rem = trial - mag;
      cell_d.quo = {cell_i.quo[W-2:0], 1'b1};
    end else begin
      cell_d.rem = trial;
      cell_d.quo = {cell_i.quo[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

@@ rtl/core/q13_mul.sv @@
// q13_mul: registered 32x32 signed multiply, fixed-point scale and final result
// depends on q13_pkg
module q13_mul #(
  parameter int unsigned FracBits = q13_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  q13_pkg::cell_t            cell_i,
  output logic                      valid_o,
  output logic [q13_pkg::WordW-1:0] result_o,
  output logic                      ovf_o
);

  localparam int unsigned W = q13_pkg::WordW;

  logic              v1_q, v2_q;
  q13_pkg::op_e      op1_q;
  logic              neg1_q, pass1_q;
  logic [W-1:0]      res1_q, res2_q;
  logic              ovf1_q, ovf2_q;
  logic [2*W-1:0]    prod_q;
  logic [W-1:0]      mul_b;
  logic [W-1:0]      sum, dif;
  logic              pass_d, ovf_d;
  logic [W-1:0]      res_d;
  logic [2*W-1:0]    shifted;
  logic [W:0]        top;
  logic              movf;
  logic [W-1:0]      mres;

  always_comb begin
    sum = cell_i.a + cell_i.b;
    dif = cell_i.a - cell_i.b;
    mul_b = (cell_i.op == q13_pkg::OpDiv) ? cell_i.quo : cell_i.b;
    pass_d = 1'b1;
    ovf_d  = 1'b0;
    res_d  = '0;
    case (cell_i.op)
      q13_pkg::OpAdd: begin
        res_d = sum;
        ovf_d = (cell_i.a[W-1] == cell_i.b[W-1]) && (sum[W-1] != cell_i.a[W-1]);
      end
      q13_pkg::OpSub: begin
        res_d = dif;
        ovf_d = (cell_i.a[W-1] != cell_i.b[W-1]) && (dif[W-1] != cell_i.a[W-1]);
      end
      q13_pkg::OpMul: pass_d = 1'b0;
      q13_pkg::OpDiv: begin
        if (cell_i.b == '0) begin
          ovf_d = 1'b1;
        end else begin
          pass_d = 1'b0;
        end
      end
      default: pass_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cell_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= cell_i.op;
    neg1_q  <= cell_i.neg;
    prod_q  <= $signed(cell_i.a) * $signed(mul_b);
    pass1_q <= pass_d;
    ovf1_q  <= ovf_d;
    res1_q  <= res_d;
  end

  always_comb begin
    shifted = $signed(prod_q) >>> FracBits;
    top  = shifted[2*W-1:W-1];
    movf = !((top == '0) || (top == '1));
    mres = shifted[W-1:0];
    if (op1_q == q13_pkg::OpDiv && neg1_q) begin
      mres = ~mres + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res2_q  <= pass1_q ? res1_q : mres;
    ovf2_q  <= pass1_q ? ovf1_q : movf;
  end

  assign valid_o  = v2_q;
  assign result_o = res2_q;
  assign ovf_o    = ovf2_q;

endmodule

@@ rtl/core/q13_fixed_point_alu.sv @@
// q13_fixed_point_alu: top level, pipelined fixed-point add/sub/mul/div
// depends on q13_pkg, q13_cell, q13_mul
//
// Fully pipelined: one item may be started every cycle (busy is always low)
// and its result appears on result_value_o/overflow_flag_o with valid_o high
// once it has passed the row of restoring-division cells that forms the
// reciprocal, one quotient bit per cell, followed by the registered
// multiplier and its output stage. Every item walks the same row so results
// leave in order. The receiver cannot stall: each result is shown for one
// cycle only.
module q13_fixed_point_alu #(
  parameter int unsigned FracBits = q13_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command_i,
  input  logic [q13_pkg::WordW-1:0] operand_a_i,
  input  logic [q13_pkg::WordW-1:0] operand_b_i,
  output logic                      valid_o,
  output logic [q13_pkg::WordW-1:0] result_value_o,
  output logic                      overflow_flag_o
);

  localparam int unsigned NumSteps = 2 * FracBits + 1;

  q13_pkg::cell_t row [NumSteps+1];

  assign busy = 1'b0;

  always_comb begin
    row[0]       = '0;
    row[0].valid = start;
    row[0].op    = q13_pkg::op_e'(command_i);
    row[0].a     = operand_a_i;
    row[0].b     = operand_b_i;
    row[0].neg   = operand_b_i[q13_pkg::WordW-1];
  end

  for (genvar i = 0; i < NumSteps; i++) begin : g_row
    q13_cell #(.Step(i), .NumSteps(NumSteps)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(row[i]),
      .cell_o(row[i+1])
    );
  end

  q13_mul #(.FracBits(FracBits)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (row[NumSteps]),
    .valid_o (valid_o),
    .result_o(result_value_o),
    .ovf_o   (overflow_flag_o)
  );

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_quiet_after_reset : assert property (@(posedge clk_i) $rose(rst_ni) |-> !valid_o)
    else $error("result right after reset");
  a_valid_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(valid_o))
    else $error("result strobe unknown");

endmodule

@@ test/q13_alu_checker.sv @@
// q13_alu_checker: watches the item and result ports of the fixed-point alu,
// predicts each result and compares it field by field; depends on q13_pkg
`timescale 1ns / 100ps

module q13_alu_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        valid_i,
  input  logic [31:0] result_value_i,
  input  logic        overflow_flag_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  localparam int FRAC = q13_pkg::FracBitsDef;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic logic [31:0] fx_product(input logic [31:0] a, input logic [31:0] b,
                                             output logic ovf);
    logic signed [63:0] prod;
    logic signed [63:0] sh;
    logic [32:0] top;
    prod = $signed(a) * $signed(b);
    sh = prod >>> FRAC;
    top = sh[63:31];
    ovf = !(top == '0 || top == '1);
    return sh[31:0];
  endfunction

  function automatic alu_result_t alu_predict(input logic [1:0] cmd, input logic [31:0] a,
                                              input logic [31:0] b);
    alu_result_t r;
    logic [31:0] mag;
    logic [63:0] recip;
    logic ov;
    r = '0;
    case (q13_pkg::op_e'(cmd))
      q13_pkg::OpAdd: begin
        r.value = a + b;
        r.ovf = (a[31] == b[31]) && (a[31] != r.value[31]);
      end
      q13_pkg::OpSub: begin
        r.value = a - b;
        r.ovf = (a[31] != b[31]) && (a[31] != r.value[31]);
      end
      q13_pkg::OpMul: begin
        r.value = fx_product(a, b, ov);
        r.ovf = ov;
      end
      default: begin
        if (b == '0) begin
          r.value = '0;
          r.ovf = 1'b1;
        end else begin
          mag = b[31] ? 32'd0 - b : b;
          recip = (64'd1 << (2 * FRAC)) / {32'd0, mag};
          r.value = fx_product(a, recip[31:0], ov);
          r.ovf = ov;
          if (b[31]) r.value = 32'd0 - r.value;
        end
      end
    endcase
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (valid_i) begin
        result_count_o <= result_count_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value %h ovf %b", $time, result_value_i,
                   overflow_flag_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.value !== result_value_i || exp_r.ovf !== overflow_flag_i) begin
            $display("%0t: mismatch expected value %h ovf %b, actual value %h ovf %b",
                     $time, exp_r.value, exp_r.ovf, result_value_i, overflow_flag_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        expected_results.push_back(alu_predict(command_i, operand_a_i, operand_b_i));
    end
  end
endmodule

@@ test/tb_top.sv @@
// tb_top: stimulus and verdict for q13_fixed_point_alu
// depends on q13_pkg, the alu rtl and q13_alu_checker
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY = 29;
  localparam int LIMIT   = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        valid_o;
  logic [31:0] result_value_o;
  logic        overflow_flag_o;
  int          fail_count;
  int          pending;
  int          result_count;
  int          cycle_count = 0;
  int          items_sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  q13_fixed_point_alu uut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .operand_a_i, .operand_b_i,
    .valid_o, .result_value_o, .overflow_flag_o
  );

  q13_alu_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .operand_a_i,
    .operand_b_i, .valid_i(valid_o), .result_value_i(result_value_o),
    .overflow_flag_i(overflow_flag_o), .fail_count_o(fail_count),
    .pending_o(pending), .result_count_o(result_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h2000 : 32'hffff_e000;
      4: return $urandom_range(0, 1) ? {$urandom} >>> $urandom_range(0, 31)
                                      : -($urandom >> $urandom_range(0, 31));
      5: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // one item: held until accepted, with optional idle cycles first
  task automatic send_item(input q13_pkg::op_e op, input logic [31:0] a,
                           input logic [31:0] b, input bit gaps);
    if (gaps) begin
      while ($urandom_range(0, 99) < 32) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    command_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  initial begin
    logic [31:0] edge_vals [6];
    int wait_cycles;
    edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h2000, 32'h1};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      send_item(q13_pkg::op_e'(i), edge_vals[i], edge_vals[i + 1], 1'b0);
      send_item(q13_pkg::op_e'(i), edge_vals[5 - i], edge_vals[i], 1'b0);
    end
    send_item(q13_pkg::OpDiv, 32'h1234_5678, 32'h0, 1'b0);
    send_item(q13_pkg::OpDiv, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(q13_pkg::OpDiv, 32'h7fff_ffff, 32'h1, 1'b0);
    send_item(q13_pkg::OpDiv, 32'h0000_2000, 32'hffff_ffff, 1'b0);
    send_item(q13_pkg::OpMul, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(q13_pkg::OpMul, 32'hffff_ffff, 32'h0000_0001, 1'b0);
    send_item(q13_pkg::OpAdd, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_item(q13_pkg::OpSub, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    for (int i = 0; i < 1700; i++) begin
      send_item(q13_pkg::op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                !(i >= 400 && i < 700));
      if (i == 1000) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < 2 * LATENCY) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    $display("sent %0d items over all four commands, %0d results checked", items_sent,
             result_count);
    $display("operands covered extremes, zero divisors, powers of two and random words");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
